/* src/lpva_pkg.sv */
// Shared types, constants and tables for the log-probability vector agreement unit
`timescale 1ns / 1ps
`default_nettype none
package lpva_pkg;

   localparam int Q_W    = 24;  // Q8.16 log probability
   localparam int SUM_W  = 37;  // running sum, Q.16
   localparam int MUL_W  = 32;  // shared multiplier operand width
   localparam int PROD_W = 64;  // shared multiplier product width
   localparam int R_W    = 31;  // Q.30 values up to 1.0
   localparam int LN_W   = 23;  // signed Q.16 natural log result
   localparam int MAG_W  = 21;  // magnitude of a Q.16 log2 value
   localparam int FRAC_W = 16;  // fraction bits of log2 / exponent
   localparam int P_W    = 5;   // leading-one position / exponent shift
   localparam int IDX_W  = 4;   // iteration counter over FRAC_W steps

   localparam logic signed [Q_W-1:0]   FLOOR_Q16 = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [Q_W-1:0]          EXP_LIMIT = 24'd1441792;   // 22.0 in Q.16
   localparam logic [MUL_W-1:0]        LOG2E_Q30 = 32'd1549082005;
   localparam logic [MUL_W-1:0]        LN2_Q30   = 32'd744261118;
   localparam logic [MUL_W-1:0]        ONE_Q30   = 32'h4000_0000;
   localparam logic [PROD_W-1:0]       HALF_Q30  = 64'h0000_0000_2000_0000;
   localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [IDX_W-1:0]        IDX_LAST  = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXP_INIT,
      S_EXP_Y,
      S_EXP_BIT,
      S_EXP_ACC,
      S_EXP_END,
      S_LN_INIT,
      S_LN_SQ_MUL,
      S_LN_SQ,
      S_LN_SC_MUL,
      S_LN_END,
      S_LSE,
      S_DONE
   } lpva_state_type;

   typedef enum logic [2:0] {
      STEP_EA,
      STEP_EB,
      STEP_LA,
      STEP_LB,
      STEP_LSE_E,
      STEP_LSE_L
   } lpva_step_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lpva_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lpva_sts_type;

   typedef logic [15:0][29:0] pow_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > n) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Factors 2^(-2^-(i+1)) in Q.30, each the square root of the one before
   function automatic pow_tab_type pow_table();
      pow_tab_type t;
      logic [63:0] s;
      s = isqrt64(64'd1 << 59);
      t[0] = s[29:0];
      for (int i = 1; i < 16; i++) begin
         s = isqrt64({4'd0, t[i-1], 30'd0});
         t[i] = s[29:0];
      end
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = pow_table();

   function automatic logic signed [Q_W-1:0] clamp_log(input logic signed [25:0] v);
      logic signed [Q_W-1:0] res;
      if (v < 26'(FLOOR_Q16)) res = FLOOR_Q16;
      else if (v > 26'sd0) res = '0;
      else res = v[Q_W-1:0];
      return res;
   endfunction

endpackage
`default_nettype wire

/* src/lpva_if.sv */
// Request and response channel interfaces of the agreement unit
`timescale 1ns / 1ps
`default_nettype none
interface lpva_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpva_pkg::Q_W-1:0]     log_a;
   logic signed [lpva_pkg::Q_W-1:0]     log_b;
   logic                                is_last;
   modport source (output valid, log_a, log_b, is_last, input ready);
   modport sink   (input valid, log_a, log_b, is_last, output ready);
endinterface

interface lpva_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpva_pkg::SUM_W-1:0]   log_likelihood;
   modport source (output valid, log_likelihood, input ready);
   modport sink   (input valid, log_likelihood, output ready);
endinterface
`default_nettype wire

/* src/lpva_mul.sv */
// Shared 32x32 unsigned multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module lpva_mul import lpva_pkg::*; (
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

/* src/lpva_core.sv */
// Sequencer for exp / ln / log-sum-exp of one dimension over the shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module lpva_core import lpva_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  lpva_ctl_type          ctl,
   input  logic signed [Q_W-1:0] in_a,
   input  logic signed [Q_W-1:0] in_b,
   output lpva_sts_type          sts,
   output logic signed [Q_W-1:0] term,
   output logic [MUL_W-1:0]      mul_a,
   output logic [MUL_W-1:0]      mul_b,
   input  logic [PROD_W-1:0]     mul_p
);

   lpva_state_type        state_ff, state_in;
   lpva_step_type         step_ff;
   logic [Q_W-1:0]        m_ff;
   logic [Q_W-1:0]        m_b_ff;
   logic signed [Q_W-1:0] lh1_ff;
   logic signed [Q_W-1:0] lh0_ff;
   logic signed [Q_W-1:0] hi_ff;
   logic signed [Q_W-1:0] term_ff;
   logic signed [LN_W-1:0] la_ff;
   logic [R_W-1:0]        ea_ff;
   logic [R_W-1:0]        eb_ff;
   logic [R_W-1:0]        r_ff;
   logic [P_W-1:0]        k_ff;
   logic [FRAC_W-1:0]     f_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [R_W-1:0]        z_ff;
   logic [FRAC_W-1:0]     frac_ff;
   logic [P_W-1:0]        p_ff;
   logic [MUL_W-1:0]      v_ff;

   logic signed [Q_W-1:0] a_clip, b_clip;
   logic [PROD_W-1:0]     prod_round;
   logic [R_W-1:0]        exp_res;
   logic                  ea_one, eb_one;
   logic [P_W-1:0]        p_enc;
   logic [MUL_W-1:0]      norm;
   logic [MUL_W-1:0]      sq;
   logic signed [21:0]    l2;
   logic                  ln_neg;
   logic [MAG_W-1:0]      ln_mag;
   logic [MAG_W-1:0]      ln_val;
   logic signed [LN_W-1:0] ln_res;
   logic signed [Q_W-1:0] hi, lo;
   logic                  hi_floor, lo_floor;

   // Shared datapath helpers
   always_comb begin
      a_clip     = (!in_a[Q_W-1] && in_a != '0) ? '0 : in_a;
      b_clip     = (!in_b[Q_W-1] && in_b != '0) ? '0 : in_b;
      prod_round = mul_p + HALF_Q30;
      exp_res    = r_ff >> k_ff;
      ea_one     = MUL_W'(ea_ff) >= ONE_Q30;
      eb_one     = MUL_W'(exp_res) >= ONE_Q30;
      p_enc      = '0;
      for (int i = 0; i < MUL_W; i++) begin
         if (v_ff[i]) p_enc = P_W'(i);
      end
      norm   = v_ff << (~p_enc);
      sq     = mul_p[61:30];
      l2     = $signed({1'b0, p_ff, frac_ff}) - 22'sd1966080;
      ln_neg = l2[21];
      ln_mag = ln_neg ? MAG_W'(-l2) : l2[MAG_W-1:0];
      ln_val = prod_round[50:30];
      ln_res = ln_neg ? -$signed({2'b0, ln_val}) : $signed({2'b0, ln_val});
      hi       = (lh0_ff > lh1_ff) ? lh0_ff : lh1_ff;
      lo       = (lh0_ff > lh1_ff) ? lh1_ff : lh0_ff;
      hi_floor = hi == FLOOR_Q16;
      lo_floor = lo == FLOOR_Q16;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (ctl.start) state_in = S_EXP_INIT;
         S_EXP_INIT:  state_in = (m_ff >= EXP_LIMIT) ? S_EXP_END : S_EXP_Y;
         S_EXP_Y:     state_in = S_EXP_BIT;
         S_EXP_BIT: begin
            if (f_ff[FRAC_W-1]) state_in = S_EXP_ACC;
            else if (idx_ff == IDX_LAST) state_in = S_EXP_END;
         end
         S_EXP_ACC:   state_in = (idx_ff == IDX_LAST) ? S_EXP_END : S_EXP_BIT;
         S_EXP_END: begin
            unique case (step_ff)
               STEP_EA:    state_in = S_EXP_INIT;
               STEP_EB:    state_in = (ea_one || eb_one) ? S_LSE : S_LN_INIT;
               STEP_LSE_E: state_in = S_LN_INIT;
               default:    state_in = S_DONE;
            endcase
         end
         S_LN_INIT:   state_in = S_LN_SQ_MUL;
         S_LN_SQ_MUL: state_in = S_LN_SQ;
         S_LN_SQ:     state_in = (idx_ff == IDX_LAST) ? S_LN_SC_MUL : S_LN_SQ_MUL;
         S_LN_SC_MUL: state_in = S_LN_END;
         S_LN_END: begin
            unique case (step_ff)
               STEP_LA: state_in = S_LN_INIT;
               STEP_LB: state_in = S_LSE;
               default: state_in = S_DONE;
            endcase
         end
         S_LSE:       state_in = (hi_floor || lo_floor) ? S_DONE : S_EXP_INIT;
         S_DONE:      if (ctl.ack) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs: multiplier operands and status
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_EXP_INIT: begin
            mul_a = MUL_W'(m_ff);
            mul_b = LOG2E_Q30;
         end
         S_EXP_BIT: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(POW_TAB[idx_ff]);
         end
         S_LN_SQ_MUL: begin
            mul_a = MUL_W'(z_ff);
            mul_b = MUL_W'(z_ff);
         end
         S_LN_SC_MUL: begin
            mul_a = MUL_W'(ln_mag);
            mul_b = LN2_Q30;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      sts.idle = state_ff == S_IDLE;
      sts.done = state_ff == S_DONE;
   end

   assign term = term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               m_ff    <= Q_W'(-a_clip);
               m_b_ff  <= Q_W'(-b_clip);
               step_ff <= STEP_EA;
               if (a_clip == FLOOR_Q16 || b_clip == FLOOR_Q16) lh1_ff <= FLOOR_Q16;
               else lh1_ff <= clamp_log(26'(a_clip) + 26'(b_clip));
            end
         end
         S_EXP_INIT: begin
            if (m_ff >= EXP_LIMIT) begin
               r_ff <= '0;
               k_ff <= '0;
            end
         end
         S_EXP_Y: begin
            k_ff   <= prod_round[50:46];
            f_ff   <= prod_round[45:30];
            r_ff   <= R_W'(ONE_Q30);
            idx_ff <= '0;
         end
         S_EXP_BIT: begin
            if (!f_ff[FRAC_W-1]) begin
               f_ff   <= f_ff << 1;
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_EXP_ACC: begin
            r_ff   <= prod_round[60:30];
            f_ff   <= f_ff << 1;
            idx_ff <= idx_ff + 1'b1;
         end
         S_EXP_END: begin
            unique case (step_ff)
               STEP_EA: begin
                  ea_ff   <= exp_res;
                  m_ff    <= m_b_ff;
                  step_ff <= STEP_EB;
               end
               STEP_EB: begin
                  eb_ff <= exp_res;
                  if (ea_one || eb_one) begin
                     lh0_ff <= FLOOR_Q16;
                  end else begin
                     v_ff    <= ONE_Q30 - MUL_W'(ea_ff);
                     step_ff <= STEP_LA;
                  end
               end
               STEP_LSE_E: begin
                  v_ff    <= ONE_Q30 + MUL_W'(exp_res);
                  step_ff <= STEP_LSE_L;
               end
               default: begin
                  step_ff <= step_ff;
               end
            endcase
         end
         S_LN_INIT: begin
            p_ff    <= p_enc;
            z_ff    <= norm[MUL_W-1:1];
            frac_ff <= '0;
            idx_ff  <= '0;
         end
         S_LN_SQ: begin
            // Square above 2.0: halve and shift in a one
            if (sq[MUL_W-1]) begin
               z_ff    <= sq[MUL_W-1:1];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               z_ff    <= sq[R_W-1:0];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b0};
            end
            idx_ff <= idx_ff + 1'b1;
         end
         S_LN_END: begin
            unique case (step_ff)
               STEP_LA: begin
                  la_ff   <= ln_res;
                  v_ff    <= ONE_Q30 - MUL_W'(eb_ff);
                  step_ff <= STEP_LB;
               end
               STEP_LB: begin
                  lh0_ff <= clamp_log(26'(la_ff) + 26'(ln_res));
               end
               default: begin
                  term_ff <= clamp_log(26'(hi_ff) + 26'(ln_res));
               end
            endcase
         end
         S_LSE: begin
            hi_ff <= hi;
            if (hi_floor) begin
               term_ff <= FLOOR_Q16;
            end else if (lo_floor) begin
               term_ff <= hi;
            end else begin
               m_ff    <= Q_W'(25'(hi) - 25'(lo));
               step_ff <= STEP_LSE_E;
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == S_IDLE)
      else $error("start outside idle");

   a_ln_normalized: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LN_SQ_MUL |-> z_ff[R_W-1])
      else $error("ln mantissa lost normalization");

   a_exp_r_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXP_BIT |-> MUL_W'(r_ff) <= ONE_Q30)
      else $error("exp product above one");

   a_acc_follows_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXP_ACC |-> $past(state_ff) == S_EXP_BIT)
      else $error("exp accumulate without issue");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> (term_ff[Q_W-1] || term_ff == '0))
      else $error("term above zero");

endmodule
`default_nettype wire

/* src/log_prob_vector_agreement_unit.sv */
// Top level of the log-probability vector agreement unit
`timescale 1ns / 1ps
`default_nettype none
// Each request transfer carries one dimension: the Q8.16 log probabilities log_a and
// log_b of two Bernoulli elements and an is_last flag. The unit forms the log of the
// probability that the two elements agree, log(e^a e^b + (1-e^a)(1-e^b)), with
// -128.0 standing for log zero, and adds it to a 37-bit Q.16 running sum that
// saturates at -2^20 (raw code -2^36). The dimension marked is_last sends the sum
// out as one response transfer and clears it. Every exp and ln step of a dimension
// goes through a single shared 32x32 multiplier with a registered product, with up
// to three exp and three ln evaluations of 16 iterations each. Request ready is high
// only while the sequencer is idle. The response sits in an output register, so the
// next dimension is taken while a finished sum waits; a last dimension that completes
// before that sum is taken holds until the response slot frees.
module log_prob_vector_agreement_unit import lpva_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lpva_req_if.sink   req_if,
   lpva_rsp_if.source rsp_if
);

   lpva_ctl_type          ctl;
   lpva_sts_type          sts;
   logic signed [Q_W-1:0] term;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]     mul_p;

   logic                    last_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_data_ff;
   logic                    req_xfer;
   logic                    finish;
   logic signed [SUM_W:0]   sum_ext;

   lpva_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   lpva_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .in_a  (req_if.log_a),
      .in_b  (req_if.log_b),
      .sts   (sts),
      .term  (term),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign req_if.ready = sts.idle;
   assign req_xfer     = req_if.valid && sts.idle;

   // Hold a finished last dimension while the previous sum still waits
   assign ctl.start = req_xfer;
   assign ctl.ack   = !last_ff || !rsp_valid_ff || rsp_if.ready;
   assign finish    = sts.done && ctl.ack;

   // Add the term and saturate at the floor of the sum
   always_comb begin
      sum_ext = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(term);
      if (sum_ext < (SUM_W+1)'(SUM_MIN)) sum_in = SUM_MIN;
      else if (sum_ext > 0) sum_in = '0;
      else sum_in = sum_ext[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new sum refills the slot in the same cycle the old one leaves
         if (finish && last_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;
         if (finish) begin
            if (last_ff) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) last_ff <= req_if.is_last;
      if (finish && last_ff) rsp_data_ff <= sum_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.log_likelihood = rsp_data_ff;

endmodule
`default_nettype wire
